[rtl/core/usd_pkg.sv]
package usd_pkg;

    localparam int SOCK_W = 16;

    typedef enum logic [1:0]
    {
        KIND_BIND   = 2'd0,
        KIND_UNBIND = 2'd1,
        KIND_PACKET = 2'd2,
        KIND_NONE   = 2'd3
    } kind_t;

    typedef enum logic [3:0]
    {
        ST_DELIVER   = 4'd0,
        ST_BOUND     = 4'd1,
        ST_UNBOUND   = 4'd2,
        ST_BAD_CSUM  = 4'd3,
        ST_NO_SOCKET = 4'd4,
        ST_DUP_ID    = 4'd5,
        ST_UNKNOWN   = 4'd6,
        ST_EXHAUSTED = 4'd7,
        ST_FULL      = 4'd8
    } status_t;

    localparam logic CFG_EPH_FIRST = 1'b0;
    localparam logic CFG_EPH_LIMIT = 1'b1;
    localparam logic [7:0] IF_ANY = 8'hFF;

    typedef struct packed
    {
        logic [1:0]  kind;
        logic [15:0] sock_id;
        logic [7:0]  gate_index;
        logic [15:0] local_port;
        logic [15:0] remote_port;
        logic [31:0] local_addr;
        logic [31:0] remote_addr;
        logic [7:0]  interface_id;
        logic        bit_error;
    } item_t;

    typedef struct packed
    {
        logic [3:0]  status;
        logic [15:0] out_sock_id;
        logic [7:0]  out_gate;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic [7:0]  out_interface;
        logic        last;
    } result_t;

endpackage

[rtl/core/usd_front.sv]
module usd_front
    import usd_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  item_t in_item,
    output logic  q_valid,
    input  logic  q_ready,
    output item_t q_item
);

    // Two-entry queue between intake and execution.
    item_t      mem_reg [2];
    logic       wr_reg, wr_next;
    logic       rd_reg, rd_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push, pop;

    assign in_ready = (cnt_reg != 2'd2);
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_item   = mem_reg[rd_reg];
    assign push     = in_valid && in_ready && (in_item.kind != KIND_NONE);
    assign pop      = q_valid && q_ready;

    always_comb
    begin
        wr_next  = push ? ~wr_reg : wr_reg;
        rd_next  = pop ? ~rd_reg : rd_reg;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= in_item;
        end
    end

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n) cnt_reg != 2'd3)
        else $error("queue count out of range");
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg == 2'd2 |-> !push) else $error("push into full queue");
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg == 2'd0 |-> !pop) else $error("pop from empty queue");

endmodule

[rtl/core/usd_back.sv]
module usd_back
    import usd_pkg::*;
#(
    parameter int SOCKETS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_valid,
    output logic        q_ready,
    input  item_t       q_item,
    input  logic        cfg_we_first,
    input  logic        cfg_we_limit,
    input  logic [15:0] cfg_value,
    output logic        out_valid,
    input  logic        out_ready,
    output result_t     out_res
);

    localparam int IW = (SOCKETS > 1) ? $clog2(SOCKETS) : 1;

    typedef enum logic [1:0]
    {
        S_IDLE,
        S_SCAN,
        S_EMIT
    } state_t;

    state_t          state_reg, state_next;
    item_t           item_reg, item_next;
    logic [IW-1:0]   idx_reg, idx_next;
    logic            any_reg, any_next;
    logic            pend_reg, pend_next;
    result_t         pend_res_reg, pend_res_next;
    logic            out_valid_reg, out_valid_next;
    result_t         out_res_reg, out_res_next;
    logic [15:0]     eph_limit_reg, eph_limit_next;
    logic [15:0]     next_port_reg, next_port_next;

    logic [SOCKETS-1:0] valid_reg, valid_next;
    logic [15:0] s_id_reg    [SOCKETS];
    logic [7:0]  s_gate_reg  [SOCKETS];
    logic [15:0] s_lport_reg [SOCKETS];
    logic [15:0] s_rport_reg [SOCKETS];
    logic [31:0] s_laddr_reg [SOCKETS];
    logic [31:0] s_raddr_reg [SOCKETS];
    logic [7:0]  s_if_reg    [SOCKETS];
    logic        s_po_reg    [SOCKETS];

    logic [SOCKETS-1:0] id_hit;
    logic               dup;
    logic               found_free;
    logic [IW-1:0]      free_idx;
    logic [IW-1:0]      hit_idx;
    logic               slot_match;
    logic               idx_last;
    logic               out_free;
    logic               slot_we;
    logic [15:0]        bind_port;
    result_t            bres;
    result_t            ires;

    assign out_free  = !out_valid_reg || out_ready;
    assign q_ready   = (state_reg == S_IDLE) && out_free;
    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;
    assign idx_last  = ({{(32-IW){1'b0}}, idx_reg} == SOCKETS - 1);
    assign bind_port = (q_item.local_port == 16'd0) ? next_port_reg : q_item.local_port;

    // Id search and lowest free slot over the queue head.
    always_comb
    begin
        dup        = 1'b0;
        found_free = 1'b0;
        free_idx   = '0;
        hit_idx    = '0;
        for (int i = SOCKETS - 1; i >= 0; i--)
        begin
            id_hit[i] = valid_reg[i] && (s_id_reg[i] == q_item.sock_id);
            if (id_hit[i])
            begin
                dup     = 1'b1;
                hit_idx = IW'(i);
            end
            if (!valid_reg[i])
            begin
                found_free = 1'b1;
                free_idx   = IW'(i);
            end
        end
    end

    always_comb
    begin
        slot_match = valid_reg[idx_reg] && (s_lport_reg[idx_reg] == item_reg.local_port) &&
            (s_po_reg[idx_reg] ||
             ((s_rport_reg[idx_reg] == 16'd0 || s_rport_reg[idx_reg] == item_reg.remote_port) &&
              (s_laddr_reg[idx_reg] == 32'd0 || s_laddr_reg[idx_reg] == item_reg.local_addr) &&
              (s_raddr_reg[idx_reg] == 32'd0 || s_raddr_reg[idx_reg] == item_reg.remote_addr) &&
              (s_if_reg[idx_reg] == IF_ANY || s_if_reg[idx_reg] == item_reg.interface_id)));
    end

    always_comb
    begin
        bres = '0;
        bres.out_sock_id = q_item.sock_id;
        bres.last = 1'b1;
        bres.src_addr = item_reg.remote_addr;
        bres.dst_addr = item_reg.local_addr;
        bres.src_port = item_reg.remote_port;
        bres.dst_port = item_reg.local_port;
        bres.out_interface = item_reg.interface_id;
        bres.out_sock_id = s_id_reg[idx_reg];
        bres.out_gate = s_gate_reg[idx_reg];
        bres.status = ST_DELIVER;
        bres.last = 1'b0;
    end

    always_comb
    begin
        state_next     = state_reg;
        item_next      = item_reg;
        idx_next       = idx_reg;
        any_next       = any_reg;
        pend_next      = pend_reg;
        pend_res_next  = pend_res_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_res_next   = out_res_reg;
        eph_limit_next = eph_limit_reg;
        next_port_next = next_port_reg;
        valid_next     = valid_reg;
        slot_we        = 1'b0;
        ires           = '0;
        if (cfg_we_first)
        begin
            next_port_next = cfg_value;
        end
        if (cfg_we_limit)
        begin
            eph_limit_next = cfg_value;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (q_valid && out_free)
                begin
                    item_next        = q_item;
                    ires.out_sock_id = q_item.sock_id;
                    ires.last        = 1'b1;
                    out_valid_next   = 1'b1;
                    case (q_item.kind)
                        KIND_BIND:
                        begin
                            ires.out_gate = q_item.gate_index;
                            if (dup)
                            begin
                                ires.status = ST_DUP_ID;
                            end
                            else if (!found_free)
                            begin
                                ires.status = ST_FULL;
                            end
                            else if (q_item.local_port == 16'd0 &&
                                     (next_port_reg == eph_limit_reg ||
                                      next_port_reg == 16'd0))
                            begin
                                ires.status = ST_EXHAUSTED;
                            end
                            else
                            begin
                                ires.status          = ST_BOUND;
                                ires.dst_port        = bind_port;
                                valid_next[free_idx] = 1'b1;
                                slot_we              = 1'b1;
                                if (q_item.local_port == 16'd0)
                                begin
                                    next_port_next = next_port_reg + 16'd1;
                                end
                            end
                        end
                        KIND_UNBIND:
                        begin
                            if (dup)
                            begin
                                ires.status         = ST_UNBOUND;
                                valid_next[hit_idx] = 1'b0;
                            end
                            else
                            begin
                                ires.status = ST_UNKNOWN;
                            end
                        end
                        default:
                        begin
                            ires.out_sock_id   = '0;
                            ires.src_addr      = q_item.remote_addr;
                            ires.dst_addr      = q_item.local_addr;
                            ires.src_port      = q_item.remote_port;
                            ires.dst_port      = q_item.local_port;
                            ires.out_interface = q_item.interface_id;
                            if (q_item.bit_error)
                            begin
                                ires.status = ST_BAD_CSUM;
                            end
                            else
                            begin
                                out_valid_next = 1'b0;
                                idx_next       = '0;
                                any_next       = 1'b0;
                                pend_next      = 1'b0;
                                state_next     = S_SCAN;
                            end
                        end
                    endcase
                    if (out_valid_next)
                    begin
                        out_res_next = ires;
                    end
                end
            end
            S_SCAN:
            begin
                // One slot per cycle, unless a new match finds the output busy; a match is held
                // until the next match or the scan end decides its last mark.
                if (!pend_reg || !slot_match || out_free)
                begin
                    if (slot_match)
                    begin
                        if (pend_reg)
                        begin
                            out_valid_next = 1'b1;
                            out_res_next   = pend_res_reg;
                        end
                        pend_next     = 1'b1;
                        pend_res_next = bres;
                        any_next      = 1'b1;
                    end
                    if (idx_last)
                    begin
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                    if (pend_reg)
                    begin
                        out_res_next      = pend_res_reg;
                        out_res_next.last = 1'b1;
                    end
                    else
                    begin
                        ires.status        = ST_NO_SOCKET;
                        ires.src_addr      = item_reg.remote_addr;
                        ires.dst_addr      = item_reg.local_addr;
                        ires.src_port      = item_reg.remote_port;
                        ires.dst_port      = item_reg.local_port;
                        ires.out_interface = item_reg.interface_id;
                        ires.last          = 1'b1;
                        out_res_next       = ires;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            item_reg      <= '0;
            idx_reg       <= '0;
            any_reg       <= 1'b0;
            pend_reg      <= 1'b0;
            pend_res_reg  <= '0;
            out_valid_reg <= 1'b0;
            out_res_reg   <= '0;
            valid_reg     <= '0;
            eph_limit_reg <= 16'd5000;
            next_port_reg <= 16'd1024;
        end
        else
        begin
            state_reg     <= state_next;
            item_reg      <= item_next;
            idx_reg       <= idx_next;
            any_reg       <= any_next;
            pend_reg      <= pend_next;
            pend_res_reg  <= pend_res_next;
            out_valid_reg <= out_valid_next;
            out_res_reg   <= out_res_next;
            valid_reg     <= valid_next;
            eph_limit_reg <= eph_limit_next;
            next_port_reg <= next_port_next;
        end
    end

    // Socket table fields; a bind fills the lowest free slot.
    always_ff @(posedge clk)
    begin
        if (slot_we)
        begin
            s_id_reg[free_idx]    <= q_item.sock_id;
            s_gate_reg[free_idx]  <= q_item.gate_index;
            s_lport_reg[free_idx] <= bind_port;
            s_rport_reg[free_idx] <= q_item.remote_port;
            s_laddr_reg[free_idx] <= q_item.local_addr;
            s_raddr_reg[free_idx] <= q_item.remote_addr;
            s_if_reg[free_idx]    <= q_item.interface_id;
            s_po_reg[free_idx]    <= (q_item.local_addr == 32'd0) &&
                (q_item.remote_addr == 32'd0) &&
                (q_item.remote_port == 16'd0) &&
                (q_item.interface_id == IF_ANY);
        end
    end

    a_pend_any: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg && state_reg != S_IDLE |-> any_reg) else $error("pending without match");
    a_take_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_ready |-> state_reg == S_IDLE) else $error("take while busy");
    a_emit_last: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_EMIT && out_free |=> out_valid_reg && out_res_reg.last)
        else $error("scan end without last result");

endmodule

[rtl/core/udp_socket_demultiplexer_core.sv]
// Bind, unbind and dropped-checksum items pass one queue stage and then the registered
// execution state before their result appears.
// Control items can follow back to back while the output is free; a clean packet scans
// the socket table one slot per cycle unless the output stalls, and takes no new item meanwhile.
// Reset (rst_n low, asynchronous) empties the queue and the table and loads
// ephemeral_first = 1024, ephemeral_limit = 5000.
module udp_socket_demultiplexer_core
    import usd_pkg::*;
#(
    parameter int SOCKETS = 16
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // bits lowest up: kind[1:0]
    input  logic [1:0]   s_axis_tuser,
    // bits lowest up: sock_id, gate_index, local_port, remote_port,
    // local_addr, remote_addr, interface_id, bit_error, zero fill
    input  logic [135:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // bits lowest up: status[3:0]
    output logic [3:0]   m_axis_tuser,
    // bits lowest up: out_sock_id, out_gate, src_addr, dst_addr,
    // src_port, dst_port, out_interface
    output logic [127:0] m_axis_tdata,
    // last result of an input item
    output logic         m_axis_tlast,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic         cfg_index,
    input  logic [15:0]  cfg_data
);

    item_t   in_item;
    item_t   q_item;
    logic    q_valid, q_ready;
    result_t res;

    // Unpack the inbound transaction.
    assign in_item.kind         = s_axis_tuser;
    assign in_item.sock_id      = s_axis_tdata[15:0];
    assign in_item.gate_index   = s_axis_tdata[23:16];
    assign in_item.local_port   = s_axis_tdata[39:24];
    assign in_item.remote_port  = s_axis_tdata[55:40];
    assign in_item.local_addr   = s_axis_tdata[87:56];
    assign in_item.remote_addr  = s_axis_tdata[119:88];
    assign in_item.interface_id = s_axis_tdata[127:120];
    assign in_item.bit_error    = s_axis_tdata[128];

    // Always taken; the user sends writes only while the block is idle; the block never checks.
    assign cfg_ready = 1'b1;

    usd_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_item  (in_item),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_item   (q_item)
    );

    usd_back #(.SOCKETS(SOCKETS)) u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_ready      (q_ready),
        .q_item       (q_item),
        .cfg_we_first (cfg_valid && (cfg_index == CFG_EPH_FIRST)),
        .cfg_we_limit (cfg_valid && (cfg_index == CFG_EPH_LIMIT)),
        .cfg_value    (cfg_data),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .out_res      (res)
    );

    // Pack the outbound transaction.
    assign m_axis_tuser = res.status;
    assign m_axis_tdata = {
        res.out_interface,
        res.dst_port,
        res.src_port,
        res.dst_addr,
        res.src_addr,
        res.out_gate,
        res.out_sock_id
    };
    assign m_axis_tlast = res.last;

endmodule

[tb/usd_checker.sv]
`timescale 1ns / 100ps

module usd_checker
    import usd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    input  logic         s_axis_tready,
    input  logic [1:0]   s_axis_tuser,
    input  logic [135:0] s_axis_tdata,
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic [3:0]   m_axis_tuser,
    input  logic [127:0] m_axis_tdata,
    input  logic         m_axis_tlast,
    input  logic         cfg_valid,
    input  logic         cfg_ready,
    input  logic         cfg_index,
    input  logic [15:0]  cfg_data,
    output int           errors,
    output int           pending
);

    localparam int SLOTS = 16;

    logic        used     [SLOTS];
    logic [15:0] sid_tab  [SLOTS];
    logic [7:0]  gate_tab [SLOTS];
    logic [15:0] lport_tab[SLOTS];
    logic [15:0] rport_tab[SLOTS];
    logic [31:0] laddr_tab[SLOTS];
    logic [31:0] raddr_tab[SLOTS];
    logic [7:0]  ifc_tab  [SLOTS];
    logic        any_tab  [SLOTS];
    logic [15:0] eph_limit;
    logic [15:0] next_port;

    result_t expected_results[$];

    initial errors = 0;

    task automatic report_mismatch(string what, longint unsigned want, longint unsigned got);
        $display("mismatch %s: expected %0h, got %0h at %0t", what, want, got, $realtime);
        errors++;
    endtask

    task automatic expect_result(result_t r);
        expected_results.insert(expected_results.size(), r);
    endtask

    function automatic result_t answer(status_t st, logic [15:0] sid, logic [7:0] gate,
                                       logic [15:0] dport);
        result_t r;
        r = '0;
        r.status = st;
        r.out_sock_id = sid;
        r.out_gate = gate;
        r.dst_port = dport;
        r.last = 1'b1;
        return r;
    endfunction

    function automatic result_t packet_result(status_t st, item_t it, logic [15:0] sid,
                                              logic [7:0] gate, logic last);
        result_t r;
        r.status = st;
        r.out_sock_id = sid;
        r.out_gate = gate;
        r.src_addr = it.remote_addr;
        r.dst_addr = it.local_addr;
        r.src_port = it.remote_port;
        r.dst_port = it.local_port;
        r.out_interface = it.interface_id;
        r.last = last;
        return r;
    endfunction

    function automatic int lookup_id(logic [15:0] id);
        for (int i = 0; i < SLOTS; i++)
            if (used[i] && sid_tab[i] == id)
                return i;
        return -1;
    endfunction

    // Work out the results of one accepted item and update the socket table.
    task automatic predict_socket_op(item_t it);
        int free_slot;
        int hit;
        int n;
        logic [15:0] port;
        logic ok;
        free_slot = -1;
        port = it.local_port;
        n = 0;
        case (kind_t'(it.kind))
            KIND_BIND:
            begin
                for (int i = SLOTS - 1; i >= 0; i--)
                    if (!used[i])
                        free_slot = i;
                if (lookup_id(it.sock_id) >= 0)
                    expect_result(answer(ST_DUP_ID, it.sock_id, it.gate_index, 0));
                else if (free_slot < 0)
                    expect_result(answer(ST_FULL, it.sock_id, it.gate_index, 0));
                else if (port == 0 && (next_port == eph_limit || next_port == 0))
                    expect_result(answer(ST_EXHAUSTED, it.sock_id, it.gate_index, 0));
                else
                begin
                    if (port == 0)
                    begin
                        port = next_port;
                        next_port = next_port + 16'd1;
                    end
                    used[free_slot] = 1'b1;
                    sid_tab[free_slot] = it.sock_id;
                    gate_tab[free_slot] = it.gate_index;
                    lport_tab[free_slot] = port;
                    rport_tab[free_slot] = it.remote_port;
                    laddr_tab[free_slot] = it.local_addr;
                    raddr_tab[free_slot] = it.remote_addr;
                    ifc_tab[free_slot] = it.interface_id;
                    any_tab[free_slot] = it.local_addr == 0 && it.remote_addr == 0 &&
                                         it.remote_port == 0 && it.interface_id == IF_ANY;
                    expect_result(answer(ST_BOUND, it.sock_id, it.gate_index, port));
                end
            end
            KIND_UNBIND:
            begin
                hit = lookup_id(it.sock_id);
                if (hit < 0)
                    expect_result(answer(ST_UNKNOWN, it.sock_id, 0, 0));
                else
                begin
                    used[hit] = 1'b0;
                    expect_result(answer(ST_UNBOUND, it.sock_id, 0, 0));
                end
            end
            KIND_PACKET:
            begin
                if (it.bit_error)
                    expect_result(packet_result(ST_BAD_CSUM, it, 0, 0, 1'b1));
                else
                begin
                    for (int i = 0; i < SLOTS && n < 16; i++)
                    begin
                        ok = used[i] && lport_tab[i] == it.local_port;
                        if (ok && !any_tab[i])
                            ok = (rport_tab[i] == 0 || rport_tab[i] == it.remote_port) &&
                                 (laddr_tab[i] == 0 || laddr_tab[i] == it.local_addr) &&
                                 (raddr_tab[i] == 0 || raddr_tab[i] == it.remote_addr) &&
                                 (ifc_tab[i] == IF_ANY || ifc_tab[i] == it.interface_id);
                        if (ok)
                        begin
                            expect_result(packet_result(ST_DELIVER, it, sid_tab[i],
                                                        gate_tab[i], 1'b0));
                            n++;
                        end
                    end
                    if (n == 0)
                        expect_result(packet_result(ST_NO_SOCKET, it, 0, 0, 1'b1));
                    else
                        expected_results[expected_results.size() - 1].last = 1'b1;
                end
            end
            default: ;
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        item_t it;
        result_t got;
        result_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
                used[i] = 1'b0;
            eph_limit = 16'd5000;
            next_port = 16'd1024;
            expected_results.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_EPH_FIRST)
                    next_port = cfg_data;
                else
                    eph_limit = cfg_data;
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.status = m_axis_tuser;
                got.out_sock_id = m_axis_tdata[15:0];
                got.out_gate = m_axis_tdata[23:16];
                got.src_addr = m_axis_tdata[55:24];
                got.dst_addr = m_axis_tdata[87:56];
                got.src_port = m_axis_tdata[103:88];
                got.dst_port = m_axis_tdata[119:104];
                got.out_interface = m_axis_tdata[127:120];
                got.last = m_axis_tlast;
                if (expected_results.size() == 0)
                    report_mismatch("unexpected result, status", 0, got.status);
                else
                begin
                    want = expected_results.pop_front();
                    if (got.status != want.status)
                        report_mismatch("status", want.status, got.status);
                    if (got.out_sock_id != want.out_sock_id)
                        report_mismatch("out_sock_id", want.out_sock_id, got.out_sock_id);
                    if (got.out_gate != want.out_gate)
                        report_mismatch("out_gate", want.out_gate, got.out_gate);
                    if (got.src_addr != want.src_addr)
                        report_mismatch("src_addr", want.src_addr, got.src_addr);
                    if (got.dst_addr != want.dst_addr)
                        report_mismatch("dst_addr", want.dst_addr, got.dst_addr);
                    if (got.src_port != want.src_port)
                        report_mismatch("src_port", want.src_port, got.src_port);
                    if (got.dst_port != want.dst_port)
                        report_mismatch("dst_port", want.dst_port, got.dst_port);
                    if (got.out_interface != want.out_interface)
                        report_mismatch("out_interface", want.out_interface, got.out_interface);
                    if (got.last !== want.last)
                        report_mismatch("last", want.last, got.last);
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                it.kind = s_axis_tuser;
                it.sock_id = s_axis_tdata[15:0];
                it.gate_index = s_axis_tdata[23:16];
                it.local_port = s_axis_tdata[39:24];
                it.remote_port = s_axis_tdata[55:40];
                it.local_addr = s_axis_tdata[87:56];
                it.remote_addr = s_axis_tdata[119:88];
                it.interface_id = s_axis_tdata[127:120];
                it.bit_error = s_axis_tdata[128];
                predict_socket_op(it);
            end
        end
        pending = expected_results.size();
    end

endmodule

[tb/udp_socket_demultiplexer_core_test.sv]
`timescale 1ns / 100ps

module udp_socket_demultiplexer_core_test;
    import usd_pkg::*;

    // Cycles without any transaction before the run is declared hung. A 16-result packet
    // under long output stalls stays far below this.
    localparam int HANG_LIMIT = 5000;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    // bits lowest up: kind
    logic [1:0]   s_axis_tuser;
    // bits lowest up: sock_id, gate_index, local_port, remote_port,
    // local_addr, remote_addr, interface_id, bit_error, zero fill
    logic [135:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    // bits lowest up: status
    logic [3:0]   m_axis_tuser;
    // bits lowest up: out_sock_id, out_gate, src_addr, dst_addr,
    // src_port, dst_port, out_interface
    logic [127:0] m_axis_tdata;
    logic         m_axis_tlast;
    logic         cfg_valid;
    logic         cfg_ready;
    logic         cfg_index;
    logic [15:0]  cfg_data;

    int errors;
    int pending;
    int idle_cycles;
    int stall_left;
    logic steady;     // when set, neither side inserts gaps

    udp_socket_demultiplexer_core uut
    (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tuser(s_axis_tuser),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tuser(m_axis_tuser),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tlast(m_axis_tlast),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    usd_checker checker_i
    (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tuser(s_axis_tuser),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tuser(m_axis_tuser),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tlast(m_axis_tlast),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .errors(errors),
        .pending(pending)
    );

    initial clk = 1'b0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Mostly no gap, sometimes a short one, rarely a long one.
    function automatic int gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 65)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Output side backpressure: drop tready for random stretches.
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            m_axis_tready <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else
        begin
            m_axis_tready <= 1'b1;
            stall_left <= gap_length();
        end
    end

    // Watchdog: count cycles in which no transaction happens on any channel.
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (idle_cycles == HANG_LIMIT)
        begin
            $display("udp_socket_demultiplexer_core_test: FAIL");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    function automatic item_t make_item(kind_t kind, logic [15:0] sid, logic [7:0] gate,
                                        logic [15:0] lport, logic [15:0] rport,
                                        logic [31:0] laddr, logic [31:0] raddr,
                                        logic [7:0] ifc, logic berr);
        item_t it;
        it.kind = kind;
        it.sock_id = sid;
        it.gate_index = gate;
        it.local_port = lport;
        it.remote_port = rport;
        it.local_addr = laddr;
        it.remote_addr = raddr;
        it.interface_id = ifc;
        it.bit_error = berr;
        return it;
    endfunction

    // Hold the item on the slave side until it is accepted; valid stays high afterwards
    // so back-to-back items need no lowering in between.
    task automatic send_item(item_t it);
        int gap;
        gap = gap_length();
        if (gap > 0)
        begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser = it.kind;
        s_axis_tdata = {7'b0, it.bit_error, it.interface_id, it.remote_addr, it.local_addr,
                        it.remote_port, it.local_port, it.gate_index, it.sock_id};
        do
            @(posedge clk);
        while (!s_axis_tready);
        @(negedge clk);
    endtask

    // Drop valid, drain all outstanding results, then let the clock run on idle.
    task automatic wait_idle();
        s_axis_tvalid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (30) @(negedge clk);
    endtask

    task automatic write_reg(logic idx, logic [15:0] value);
        wait_idle();
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = value;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Random item: mostly drawn from small pools so binds collide, packets hit bound
    // sockets and the table fills; a few items carry fully random fields.
    function automatic item_t random_item();
        logic [15:0] port_pool[6] = '{16'd7, 16'd80, 16'd1024, 16'd1025, 16'd0, 16'hFFFF};
        logic [31:0] addr_pool[3] = '{32'h0, 32'h0A000001, 32'hFFFFFFFF};
        logic [7:0]  ifc_pool[4] = '{8'hFF, 8'd0, 8'd126, 8'd5};
        logic [15:0] rport_pool[4] = '{16'd0, 16'd9, 16'hFFFF, 16'd1};
        item_t it;
        int r;
        logic [7:0] ifc_raw;
        r = $urandom_range(0, 99);
        if (r < 8)
        begin
            ifc_raw = $urandom_range(0, 127);
            return make_item(kind_t'($urandom_range(0, 3)), $urandom, $urandom, $urandom,
                             $urandom, $urandom, $urandom,
                             (ifc_raw == 8'd127) ? IF_ANY : ifc_raw, $urandom_range(0, 1));
        end
        it = make_item(KIND_PACKET, $urandom_range(0, 20), $urandom,
                       port_pool[$urandom_range(0, 5)], rport_pool[$urandom_range(0, 3)],
                       addr_pool[$urandom_range(0, 2)], addr_pool[$urandom_range(0, 2)],
                       ifc_pool[$urandom_range(0, 3)], $urandom_range(0, 9) == 0);
        if (r < 40)
        begin
            it.kind = KIND_BIND;
            // favor wildcard filters so port-only sockets show up often
            if ($urandom_range(0, 2) == 0)
            begin
                it.remote_port = 0;
                it.local_addr = 0;
                it.remote_addr = 0;
                it.interface_id = IF_ANY;
            end
        end
        else if (r < 60)
            it.kind = KIND_UNBIND;
        else if (r < 95)
        begin
            it.kind = KIND_PACKET;
            if (it.interface_id == IF_ANY)
                it.interface_id = 8'd0;
        end
        else
            it.kind = KIND_NONE;
        return it;
    endfunction

    initial
    begin
        rst_n = 1'b0;
        steady = 1'b0;
        stall_left = 0;
        idle_cycles = 0;
        s_axis_tvalid = 1'b0;
        s_axis_tuser = '0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_EPH_FIRST;
        cfg_data = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: port-only socket, fully filtered socket, duplicate id, ephemeral bind.
        send_item(make_item(KIND_BIND, 16'd0, 8'd1, 16'd80, 0, 0, 0, IF_ANY, 1'b0));
        send_item(make_item(KIND_BIND, 16'hFFFF, 8'hFF, 16'd80, 16'd9, 32'hFFFFFFFF,
                            32'h0A000001, 8'd126, 1'b0));
        send_item(make_item(KIND_BIND, 16'd0, 8'd7, 16'd81, 0, 0, 0, IF_ANY, 1'b0));
        send_item(make_item(KIND_BIND, 16'd2, 8'd0, 16'd0, 0, 0, 0, IF_ANY, 1'b0));
        // Packets: both sockets match, only the wildcard matches, ephemeral port,
        // no socket, checksum failure with extreme fields.
        send_item(make_item(KIND_PACKET, 0, 0, 16'd80, 16'd9, 32'hFFFFFFFF, 32'h0A000001,
                            8'd126, 1'b0));
        send_item(make_item(KIND_PACKET, 0, 0, 16'd80, 16'd1, 32'hFFFFFFFF, 32'h0A000001,
                            8'd126, 1'b0));
        send_item(make_item(KIND_PACKET, 0, 0, 16'd1024, 16'hFFFF, 0, 0, 8'd0, 1'b0));
        send_item(make_item(KIND_PACKET, 0, 0, 16'd81, 0, 0, 0, 8'd0, 1'b0));
        send_item(make_item(KIND_PACKET, 16'hFFFF, 8'hFF, 16'hFFFF, 16'hFFFF, 32'hFFFFFFFF,
                            32'hFFFFFFFF, IF_ANY, 1'b1));
        // Unbind known and unknown ids; an unused kind is silently ignored.
        send_item(make_item(KIND_UNBIND, 16'd0, 8'd3, 0, 0, 0, 0, 0, 1'b0));
        send_item(make_item(KIND_UNBIND, 16'd0, 0, 0, 0, 0, 0, 0, 1'b0));
        send_item(make_item(KIND_NONE, 16'd5, 8'd5, 16'd80, 0, 0, 0, 0, 1'b0));
        send_item(make_item(KIND_PACKET, 0, 0, 16'd80, 16'd9, 32'hFFFFFFFF, 32'h0A000001,
                            8'd0, 1'b0));
        send_item(make_item(KIND_UNBIND, 16'hFFFF, 0, 0, 0, 0, 0, 0, 1'b0));
        send_item(make_item(KIND_UNBIND, 16'd2, 0, 0, 0, 0, 0, 0, 1'b0));
        // Fill the table on one port: duplicate wins over full, then full, then a
        // packet that fans out to all sixteen sockets.
        for (int i = 0; i < 16; i++)
            send_item(make_item(KIND_BIND, 16'd100 + i, i, 16'd7, 0, 0, 0, IF_ANY, 1'b0));
        send_item(make_item(KIND_BIND, 16'd100, 0, 16'd7, 0, 0, 0, IF_ANY, 1'b0));
        send_item(make_item(KIND_BIND, 16'd200, 0, 16'd7, 0, 0, 0, IF_ANY, 1'b0));
        send_item(make_item(KIND_PACKET, 0, 0, 16'd7, 16'd3, 32'h1, 32'h2, 8'd4, 1'b0));
        for (int i = 0; i < 16; i++)
            send_item(make_item(KIND_UNBIND, 16'd100 + i, 0, 0, 0, 0, 0, 0, 1'b0));

        // Random phases, each under its own ephemeral setting.
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                1:
                begin
                    // counter wraps past 65535 to zero and then reports exhaustion
                    write_reg(CFG_EPH_LIMIT, 16'd1);
                    write_reg(CFG_EPH_FIRST, 16'hFFFE);
                end
                2:
                begin
                    write_reg(CFG_EPH_FIRST, 16'd1);
                    write_reg(CFG_EPH_LIMIT, 16'd3);
                end
                3:
                begin
                    write_reg(CFG_EPH_FIRST, 16'd1024);
                    write_reg(CFG_EPH_LIMIT, 16'hFFFF);
                end
                default: ;
            endcase
            steady = (phase == 2);
            for (int n = 0; n < 43; n++)
                send_item(random_item());
        end
        steady = 1'b0;
        wait_idle();

        if (errors == 0)
            $display("udp_socket_demultiplexer_core_test: PASS");
        else
            $display("udp_socket_demultiplexer_core_test: FAIL");
        $finish;
    end

endmodule
